FILE: sv/mlt_pkg.sv
package mlt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int PORT_COUNT        = 16;

   localparam int ADDR_W  = 48;
   localparam int PORT_W  = 4;
   localparam int STAMP_W = 32;
   localparam int TMO_W   = 16;
   localparam int COUNT_W = 7;

   localparam logic [TMO_W-1:0]   AGING_RESET = 16'd30;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  addr;
      logic [PORT_W-1:0]  port;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clear_wr;
      logic rd;
      logic chk;
      logic fin;
   } ctrl_cmd_type;

endpackage

FILE: sv/mlt_ram.sv
module mlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mlt_ctrl.sv
module mlt_ctrl #(
   parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mlt_pkg::ctrl_cmd_type            cmd,
   output logic [$clog2(TABLE_ENTRIES)-1:0] idx,
   output logic [$clog2(TABLE_ENTRIES)-1:0] chk_idx
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic          chk_ff, chk_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          last;

   assign last = (cnt_ff == LAST);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_in       = 1'b0;
      chk_idx_in   = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.chk      = chk_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd = 1'b1;
            chk_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
         chk_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_ff       <= chk_in;
         chk_idx_ff   <= chk_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign idx       = cnt_ff;
   assign chk_idx   = chk_idx_ff;

endmodule

FILE: sv/mlt_dpath.sv
module mlt_dpath #(
   parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mlt_pkg::ctrl_cmd_type              cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]   idx,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]   chk_idx,
   input  logic [1:0]                         req_cmd,
   input  logic [mlt_pkg::ADDR_W-1:0]         req_mac_address,
   input  logic [mlt_pkg::PORT_W-1:0]         req_port_number,
   input  logic                               req_refresh_on_hit,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mlt_pkg::TMO_W-1:0]          csr_data,
   output logic                               rsp_hit,
   output logic [mlt_pkg::PORT_W-1:0]         rsp_found_port,
   output logic                               rsp_status,
   output logic [mlt_pkg::COUNT_W-1:0]        rsp_removed_count
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [8:0] PORT_LIMIT = 9'(mlt_pkg::PORT_COUNT);

   mlt_pkg::cmd_type                op_ff, op_in;
   logic [mlt_pkg::ADDR_W-1:0]      mac_ff, mac_in;
   logic [mlt_pkg::PORT_W-1:0]      port_ff, port_in;
   logic                            refresh_ff, refresh_in;
   logic [mlt_pkg::STAMP_W-1:0]     seconds_ff, seconds_in;
   logic [mlt_pkg::TMO_W-1:0]       timeout_ff, timeout_in;
   logic                            found_ff, found_in;
   logic [IW-1:0]                   match_idx_ff, match_idx_in;
   logic [mlt_pkg::PORT_W-1:0]      match_port_ff, match_port_in;
   logic                            free_ff, free_in;
   logic [IW-1:0]                   free_idx_ff, free_idx_in;
   logic [mlt_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                            hit_ff, hit_in;
   logic [mlt_pkg::PORT_W-1:0]      fport_ff, fport_in;
   logic                            status_ff, status_in;
   logic [mlt_pkg::COUNT_W-1:0]     removed_ff, removed_in;

   mlt_pkg::entry_type              rd_entry, wr_entry;
   logic [$bits(mlt_pkg::entry_type)-1:0] rd_data;
   logic                            wr_en;
   logic [IW-1:0]                   wr_addr;
   logic [mlt_pkg::STAMP_W-1:0]     age;
   logic                            match, aged, port_ok, do_write;
   logic [IW-1:0]                   target;

   assign rd_entry  = mlt_pkg::entry_type'(rd_data);
   assign age       = seconds_ff - rd_entry.stamp;
   assign match     = rd_entry.valid && (rd_entry.addr == mac_ff);
   assign aged      = rd_entry.valid &&
                      (age >= {{(mlt_pkg::STAMP_W-mlt_pkg::TMO_W){1'b0}}, timeout_ff});
   assign port_ok   = ({5'b0, port_ff} < PORT_LIMIT);
   assign target    = found_ff ? match_idx_ff : free_idx_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      do_write = 1'b0;
      case (op_ff)
         mlt_pkg::CMD_LOOKUP: do_write = found_ff & refresh_ff;
         mlt_pkg::CMD_INSERT: do_write = port_ok & (found_ff | free_ff);
         default:             do_write = 1'b0;
      endcase
   end

   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = idx;
      wr_entry       = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.chk && (op_ff == mlt_pkg::CMD_TICK) && aged) begin
         wr_en          = 1'b1;
         wr_addr        = chk_idx;
         wr_entry       = rd_entry;
         wr_entry.valid = 1'b0;
      end else if (cmd.fin && do_write) begin
         wr_en          = 1'b1;
         wr_addr        = target;
         wr_entry.valid = 1'b1;
         wr_entry.addr  = mac_ff;
         wr_entry.port  = (op_ff == mlt_pkg::CMD_LOOKUP) ? match_port_ff : port_ff;
         wr_entry.stamp = seconds_ff;
      end
   end

   mlt_ram #(
      .WIDTH($bits(mlt_pkg::entry_type)),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (cmd.rd),
      .rd_addr(idx),
      .rd_data(rd_data)
   );

   always_comb begin
      op_in         = op_ff;
      mac_in        = mac_ff;
      port_in       = port_ff;
      refresh_in    = refresh_ff;
      seconds_in    = seconds_ff;
      timeout_in    = timeout_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_port_in = match_port_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      fport_in      = fport_ff;
      status_in     = status_ff;
      removed_in    = removed_ff;

      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end

      if (cmd.load) begin
         op_in      = mlt_pkg::cmd_type'(req_cmd);
         mac_in     = req_mac_address;
         port_in    = req_port_number;
         refresh_in = req_refresh_on_hit;
         found_in   = 1'b0;
         free_in    = 1'b0;
         count_in   = '0;
         if (mlt_pkg::cmd_type'(req_cmd) == mlt_pkg::CMD_TICK) begin
            seconds_in = seconds_ff + 1'b1;
         end
      end

      if (cmd.chk) begin
         if (match && !found_ff) begin
            found_in      = 1'b1;
            match_idx_in  = chk_idx;
            match_port_in = rd_entry.port;
         end
         if (!rd_entry.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx;
         end
         if ((op_ff == mlt_pkg::CMD_TICK) && aged && (count_ff != mlt_pkg::COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.fin) begin
         hit_in     = (op_ff == mlt_pkg::CMD_LOOKUP) && found_ff;
         fport_in   = ((op_ff == mlt_pkg::CMD_LOOKUP) && found_ff) ? match_port_ff : '0;
         status_in  = (op_ff == mlt_pkg::CMD_INSERT) && port_ok && !found_ff && !free_ff;
         removed_in = (op_ff == mlt_pkg::CMD_TICK) ? count_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff <= '0;
         timeout_ff <= mlt_pkg::AGING_RESET;
         op_ff      <= mlt_pkg::CMD_NONE;
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         seconds_ff <= seconds_in;
         timeout_ff <= timeout_in;
         op_ff      <= op_in;
         found_ff   <= found_in;
         free_ff    <= free_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff        <= mac_in;
      port_ff       <= port_in;
      refresh_ff    <= refresh_in;
      match_idx_ff  <= match_idx_in;
      match_port_ff <= match_port_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      fport_ff      <= fport_in;
      status_ff     <= status_in;
      removed_ff    <= removed_in;
   end

   assign rsp_hit           = hit_ff;
   assign rsp_found_port    = fport_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_count = removed_ff;

endmodule

FILE: sv/mac_learning_table_with_aging_top.sv
// MAC learning table with aging.
// req_ channel: one word per command (lookup, insert, tick) with address,
// port and refresh flag. rsp_ channel: one word per command with hit,
// found port, full status and aged-out count. csr_ channel writes the
// aging timeout; csr_ready is always high.
// The table is one single-port-read RAM of TABLE_ENTRIES entries, scanned
// one entry per cycle. Every command does a full scan: one read per entry,
// a drain step for the registered RAM read, and a finish step that updates
// the table and registers the result word. The controller then returns to
// idle, and the next word is taken only there, so a command is not taken
// before the previous one has finished its scan.
// After reset the RAM is cleared entry by entry with req_ready low.
// The result word sits in an output register; the next command is taken
// while it waits, but that command's result stalls until rsp_ready empties
// the register.
module mac_learning_table_with_aging_top #(
   parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic [mlt_pkg::ADDR_W-1:0]  req_mac_address,
   input  logic [mlt_pkg::PORT_W-1:0]  req_port_number,
   input  logic                        req_refresh_on_hit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [mlt_pkg::PORT_W-1:0]  rsp_found_port,
   output logic                        rsp_status,
   output logic [mlt_pkg::COUNT_W-1:0] rsp_removed_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mlt_pkg::TMO_W-1:0]   csr_data
);

   mlt_pkg::ctrl_cmd_type            cmd;
   logic [$clog2(TABLE_ENTRIES)-1:0] idx;
   logic [$clog2(TABLE_ENTRIES)-1:0] chk_idx;

   mlt_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .idx      (idx),
      .chk_idx  (chk_idx)
   );

   mlt_dpath #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .idx               (idx),
      .chk_idx           (chk_idx),
      .req_cmd           (req_cmd),
      .req_mac_address   (req_mac_address),
      .req_port_number   (req_port_number),
      .req_refresh_on_hit(req_refresh_on_hit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .rsp_hit           (rsp_hit),
      .rsp_found_port    (rsp_found_port),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while a scan was starting");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.fin))
      else $error("result raised without a finish step");

   a_port_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_port != '0) |-> rsp_hit)
      else $error("nonzero port on a miss");

   a_hit_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_status && (rsp_removed_count == '0))
      else $error("hit mixed with insert or tick result");

   a_no_scan_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !cmd.rd && !cmd.fin && !cmd.load)
      else $error("clear pass overlaps a command");
`endif

endmodule

FILE: dv/mac_learning_table_with_aging_checker.sv
module mac_learning_table_with_aging_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic [mlt_pkg::ADDR_W-1:0]  req_mac_address,
   input  logic [mlt_pkg::PORT_W-1:0]  req_port_number,
   input  logic                        req_refresh_on_hit,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_hit,
   input  logic [mlt_pkg::PORT_W-1:0]  rsp_found_port,
   input  logic                        rsp_status,
   input  logic [mlt_pkg::COUNT_W-1:0] rsp_removed_count,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [mlt_pkg::TMO_W-1:0]   csr_data,
   output int                          errors,
   output int                          pending_words,
   output int                          hits_seen,
   output int                          full_drops,
   output int                          aged_out
);

   localparam int SLOTS = mlt_pkg::TABLE_ENTRIES_DEF;

   typedef struct packed {
      logic                        hit;
      logic [mlt_pkg::PORT_W-1:0]  port;
      logic                        full;
      logic [mlt_pkg::COUNT_W-1:0] removed;
   } table_reply_type;

   logic                        slot_live [SLOTS];
   logic [mlt_pkg::ADDR_W-1:0]  slot_mac  [SLOTS];
   logic [mlt_pkg::PORT_W-1:0]  slot_port [SLOTS];
   logic [mlt_pkg::STAMP_W-1:0] slot_stamp[SLOTS];
   logic [mlt_pkg::STAMP_W-1:0] now_sec;
   logic [mlt_pkg::TMO_W-1:0]   aging_limit;

   table_reply_type awaited_replies[$];
   int fail_count = 0;
   int word_index = 0;
   int hit_total = 0;
   int full_total = 0;
   int aged_total = 0;

   function automatic int find_entry(logic [mlt_pkg::ADDR_W-1:0] mac);
      int found;
      found = -1;
      for (int i = 0; i < SLOTS; i++)
         if (found < 0 && slot_live[i] && slot_mac[i] == mac)
            found = i;
      return found;
   endfunction

   function automatic table_reply_type run_table_op(mlt_pkg::cmd_type op,
         logic [mlt_pkg::ADDR_W-1:0] mac, logic [mlt_pkg::PORT_W-1:0] port, logic refresh);
      table_reply_type rep;
      int slot;
      int swept;
      logic [mlt_pkg::STAMP_W-1:0] age;
      rep = '0;
      case (op)
         mlt_pkg::CMD_LOOKUP: begin
            slot = find_entry(mac);
            if (slot >= 0) begin
               rep.hit = 1'b1;
               rep.port = slot_port[slot];
               if (refresh)
                  slot_stamp[slot] = now_sec;
            end
         end
         mlt_pkg::CMD_INSERT: begin
            if (int'(port) < mlt_pkg::PORT_COUNT) begin
               slot = find_entry(mac);
               if (slot < 0)
                  for (int i = 0; i < SLOTS; i++)
                     if (slot < 0 && !slot_live[i])
                        slot = i;
               if (slot < 0) begin
                  rep.full = 1'b1;
               end else begin
                  slot_live[slot] = 1'b1;
                  slot_mac[slot] = mac;
                  slot_port[slot] = port;
                  slot_stamp[slot] = now_sec;
               end
            end
         end
         mlt_pkg::CMD_TICK: begin
            swept = 0;
            now_sec = now_sec + 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               age = now_sec - slot_stamp[i];
               if (slot_live[i] && age >= {16'd0, aging_limit}) begin
                  slot_live[i] = 1'b0;
                  if (swept < int'(mlt_pkg::COUNT_MAX))
                     swept++;
               end
            end
            rep.removed = swept[mlt_pkg::COUNT_W-1:0];
         end
         default: ;
      endcase
      return rep;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at rsp word %0d: %s", word_index, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      table_reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            slot_live[i] = 1'b0;
         now_sec = '0;
         aging_limit = mlt_pkg::AGING_RESET;
         awaited_replies.delete();
      end else begin
         if (csr_valid && csr_ready)
            aging_limit = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("rsp word with nothing outstanding");
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit got %0d want %0d", rsp_hit, want.hit));
               if (rsp_found_port !== want.port)
                  report_mismatch($sformatf("found_port got %0d want %0d",
                     rsp_found_port, want.port));
               if (rsp_status !== want.full)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_status,
                     want.full));
               if (rsp_removed_count !== want.removed)
                  report_mismatch($sformatf("removed_count got %0d want %0d",
                     rsp_removed_count, want.removed));
            end
            word_index++;
         end
         if (req_valid && req_ready) begin
            want = run_table_op(mlt_pkg::cmd_type'(req_cmd), req_mac_address,
               req_port_number, req_refresh_on_hit);
            hit_total += want.hit;
            full_total += want.full;
            aged_total += want.removed;
            awaited_replies.push_back(want);
         end
      end
      errors <= fail_count;
      pending_words <= awaited_replies.size();
      hits_seen <= hit_total;
      full_drops <= full_total;
      aged_out <= aged_total;
   end

endmodule

FILE: dv/mac_learning_table_with_aging_top_tb.sv
module mac_learning_table_with_aging_top_tb;

   localparam int RANDOM_WORDS = 1950;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int POOL_SIZE    = 96;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_cmd = mlt_pkg::CMD_LOOKUP;
   logic [mlt_pkg::ADDR_W-1:0]  req_mac_address = '0;
   logic [mlt_pkg::PORT_W-1:0]  req_port_number = '0;
   logic                        req_refresh_on_hit = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_hit;
   logic [mlt_pkg::PORT_W-1:0]  rsp_found_port;
   logic                        rsp_status;
   logic [mlt_pkg::COUNT_W-1:0] rsp_removed_count;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [mlt_pkg::TMO_W-1:0]   csr_data = '0;

   int errors;
   int pending_words;
   int hits_seen;
   int full_drops;
   int aged_out;

   int cycle_count = 0;
   int n_lookups = 0;
   int n_inserts = 0;
   int n_ticks = 0;
   int n_unused = 0;
   int n_timeouts = 0;
   int n_squeezes = 0;
   int rsp_words = 0;

   logic [mlt_pkg::ADDR_W-1:0] mac_pool[POOL_SIZE];

   mac_learning_table_with_aging_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_mac_address(req_mac_address),
      .req_port_number(req_port_number),
      .req_refresh_on_hit(req_refresh_on_hit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_found_port(rsp_found_port),
      .rsp_status(rsp_status),
      .rsp_removed_count(rsp_removed_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   mac_learning_table_with_aging_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_mac_address(req_mac_address),
      .req_port_number(req_port_number),
      .req_refresh_on_hit(req_refresh_on_hit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_found_port(rsp_found_port),
      .rsp_status(rsp_status),
      .rsp_removed_count(rsp_removed_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .errors(errors),
      .pending_words(pending_words),
      .hits_seen(hits_seen),
      .full_drops(full_drops),
      .aged_out(aged_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
            pending_words);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [mlt_pkg::ADDR_W-1:0] random_mac();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[mlt_pkg::ADDR_W-1:0];
   endfunction

   function automatic logic [mlt_pkg::ADDR_W-1:0] pick_mac(int window);
      int r;
      logic [mlt_pkg::ADDR_W-1:0] base;
      r = $urandom_range(0, 9);
      base = mac_pool[$urandom_range(0, window - 1)];
      if (r < 8)
         return base;
      if (r == 8)
         return base ^ (48'd1 << $urandom_range(0, mlt_pkg::ADDR_W - 1));
      return random_mac();
   endfunction

   function automatic int next_gap(logic eager);
      int r;
      if (eager)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(20, 90);
   endfunction

   task automatic send_word(input mlt_pkg::cmd_type op,
         input logic [mlt_pkg::ADDR_W-1:0] mac, input logic [mlt_pkg::PORT_W-1:0] port,
         input logic refresh, input int gap);
      req_valid <= 1'b1;
      req_cmd <= op;
      req_mac_address <= mac;
      req_port_number <= port;
      req_refresh_on_hit <= refresh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         mlt_pkg::CMD_LOOKUP: n_lookups++;
         mlt_pkg::CMD_INSERT: n_inserts++;
         mlt_pkg::CMD_TICK:   n_ticks++;
         default:             n_unused++;
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [mlt_pkg::TMO_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      n_timeouts++;
   endtask

   // result side: random stalls, long open stretches, and a few long hold-offs
   initial begin
      int run_left;
      int choice;
      logic squeezed;
      run_left = 0;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            rsp_words++;
         if (run_left > 0) begin
            run_left--;
         end else begin
            choice = $urandom_range(0, 999);
            if ((!squeezed && rsp_words >= 200) || choice == 0) begin
               squeezed = 1'b1;
               n_squeezes++;
               rsp_ready <= 1'b0;
               run_left = $urandom_range(300, 600);
            end else if (choice < 600) begin
               rsp_ready <= 1'b1;
               run_left = $urandom_range(0, 150);
            end else if (choice < 900) begin
               rsp_ready <= 1'b0;
               run_left = $urandom_range(0, 3);
            end else begin
               rsp_ready <= 1'b0;
               run_left = $urandom_range(20, 60);
            end
         end
      end
   end

   initial begin
      logic [mlt_pkg::ADDR_W-1:0] ones;
      int random_sent;
      int phase;
      int len;
      int window;
      int r;
      logic eager;
      logic [mlt_pkg::TMO_W-1:0] tmo;
      mlt_pkg::cmd_type op;

      ones = '1;
      random_sent = 0;
      phase = 0;
      mac_pool[0] = '0;
      mac_pool[1] = ones;
      for (int k = 2; k < POOL_SIZE; k++)
         mac_pool[k] = random_mac();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table, extreme addresses, update in place, near-miss addresses
      send_word(mlt_pkg::CMD_LOOKUP, '0, 4'd0, 1'b1, next_gap(1'b0));
      send_word(mlt_pkg::CMD_INSERT, '0, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_INSERT, ones, 4'd15, 1'b1, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, ones, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, '0, 4'd15, 1'b1, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, ones ^ 48'd1, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, 48'd1 << 47, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_INSERT, ones, 4'd9, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, ones, 4'd0, 1'b1, next_gap(1'b0));
      send_word(mlt_pkg::CMD_NONE, ones, 4'd15, 1'b1, next_gap(1'b0));
      send_word(mlt_pkg::CMD_TICK, ones, 4'd15, 1'b1, next_gap(1'b0));
      send_word(mlt_pkg::CMD_TICK, '0, 4'd0, 1'b0, next_gap(1'b0));
      drain();
      // zero timeout sweeps everything
      write_timeout('0);
      send_word(mlt_pkg::CMD_TICK, '0, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, '0, 4'd0, 1'b0, next_gap(1'b0));
      drain();
      write_timeout(16'd1);
      send_word(mlt_pkg::CMD_INSERT, mac_pool[2], 4'd5, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_TICK, '0, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_INSERT, mac_pool[3], 4'd3, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, mac_pool[3], 4'd0, 1'b1, next_gap(1'b0));
      drain();
      write_timeout(16'hFFFF);
      send_word(mlt_pkg::CMD_TICK, '0, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, mac_pool[3], 4'd0, 1'b0, next_gap(1'b0));
      drain();
      write_timeout(16'd2);
      send_word(mlt_pkg::CMD_TICK, '0, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_TICK, '0, 4'd0, 1'b0, next_gap(1'b0));
      send_word(mlt_pkg::CMD_LOOKUP, mac_pool[3], 4'd0, 1'b0, next_gap(1'b0));

      while (random_sent < RANDOM_WORDS) begin
         drain();
         eager = ($urandom_range(0, 3) == 0);
         if (phase == 1 || (phase > 1 && $urandom_range(0, 5) == 0)) begin
            // fill the table past capacity, then age it all out
            write_timeout(16'hFFFF);
            for (int k = 0; k < POOL_SIZE; k++) begin
               send_word(mlt_pkg::CMD_INSERT, mac_pool[k], 4'($urandom), 1'($urandom),
                  next_gap(eager));
               random_sent++;
               if (k % 3 == 2) begin
                  send_word(mlt_pkg::CMD_LOOKUP, pick_mac(POOL_SIZE), 4'($urandom),
                     1'($urandom), next_gap(eager));
                  random_sent++;
               end
            end
            send_word(mlt_pkg::CMD_INSERT, mac_pool[0], 4'($urandom), 1'b0,
               next_gap(eager));
            send_word(mlt_pkg::CMD_INSERT, random_mac(), 4'($urandom), 1'b0,
               next_gap(eager));
            send_word(mlt_pkg::CMD_TICK, random_mac(), 4'($urandom), 1'b0,
               next_gap(eager));
            random_sent += 3;
            drain();
            write_timeout(16'($urandom_range(0, 1)));
            send_word(mlt_pkg::CMD_TICK, random_mac(), 4'($urandom), 1'($urandom),
               next_gap(eager));
            send_word(mlt_pkg::CMD_LOOKUP, mac_pool[0], 4'($urandom), 1'($urandom),
               next_gap(eager));
            random_sent += 2;
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0)
               tmo = '0;
            else if (r == 1)
               tmo = 16'd1;
            else if (r == 2)
               tmo = 16'hFFFF;
            else if (r < 6)
               tmo = 16'($urandom_range(13, 65534));
            else
               tmo = 16'($urandom_range(2, 12));
            write_timeout(tmo);
            window = $urandom_range(8, POOL_SIZE);
            len = $urandom_range(60, 200);
            for (int k = 0; k < len; k++) begin
               r = $urandom_range(0, 99);
               if (r < 45)
                  op = mlt_pkg::CMD_LOOKUP;
               else if (r < 80)
                  op = mlt_pkg::CMD_INSERT;
               else if (r < 95)
                  op = mlt_pkg::CMD_TICK;
               else
                  op = mlt_pkg::CMD_NONE;
               send_word(op, pick_mac(window), 4'($urandom), 1'($urandom),
                  next_gap(eager));
               if (op != mlt_pkg::CMD_NONE)
                  random_sent++;
            end
         end
         phase++;
      end

      drain();
      repeat (100) @(posedge clock);

      $display("ran %0d lookups (%0d hits), %0d inserts (%0d dropped on a full table), %0d ticks",
         n_lookups, hits_seen, n_inserts, full_drops, n_ticks);
      $display("%0d entries aged out, %0d timeout writes, %0d unused commands, %0d long stalls",
         aged_out, n_timeouts, n_unused, n_squeezes);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
sv/mlt_pkg.sv
sv/mlt_ram.sv
sv/mlt_ctrl.sv
sv/mlt_dpath.sv
sv/mac_learning_table_with_aging_top.sv
dv/mac_learning_table_with_aging_checker.sv
dv/mac_learning_table_with_aging_top_tb.sv
